>>> rtl/dakh_pkg.sv
package dakh_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_OTHER   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HELD    = 2'd1,
    PH_PENDING = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_DOWN = 2'd1,
    ACT_UP   = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    RS_NONE = 3'd0,
    RS_MIN  = 3'd1,
    RS_TAIL = 3'd2,
    RS_MAX  = 3'd3,
    RS_LONG = 3'd4
  } reason_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_TAIL  = 3'd0;
  localparam logic [2:0] CFG_MIN   = 3'd1;
  localparam logic [2:0] CFG_MAX   = 3'd2;
  localparam logic [2:0] CFG_LEFT  = 3'd3;
  localparam logic [2:0] CFG_RIGHT = 3'd4;

  localparam int CfgDataW = 16;

  localparam logic [15:0] TAIL_RST  = 16'd100;
  localparam logic [15:0] MIN_RST   = 16'd50;
  localparam logic [15:0] MAX_RST   = 16'd400;
  localparam logic [7:0]  LEFT_RST  = 8'd16;
  localparam logic [7:0]  RIGHT_RST = 8'd18;

  typedef struct packed {
    op_t         operation;
    logic [31:0] key_code;
    logic [7:0]  position;
  } in_item_t;

  typedef struct packed {
    action_t     hid_action;
    logic [31:0] reported_code;
    reason_t     up_reason;
    phase_t      phase;
  } out_item_t;

  typedef struct packed {
    logic [15:0] tail_ms;
    logic [15:0] min_hold_ms;
    logic [15:0] max_hold_ms;
    logic [7:0]  left_position;
    logic [7:0]  right_position;
  } cfg_t;

endpackage

>>> rtl/dakh_engine.sv
module dakh_engine import dakh_pkg::*; #(
  parameter int TIME_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  // target must hold a 16-bit hold limit even when the timer is narrower
  localparam int TgtW = (TIME_BITS > 16) ? TIME_BITS : 16;

  phase_t                 phase_r, phase_nxt;
  logic [31:0]            held_code_r, held_code_nxt;
  logic [TIME_BITS-1:0]   elapsed_r, elapsed_nxt;
  logic                   dir_hit_r, dir_hit_nxt;
  logic [TIME_BITS-1:0]   dir_offset_r, dir_offset_nxt;
  logic [TgtW-1:0]        target_r, target_nxt;
  reason_t                reason_r, reason_nxt;

  logic                   is_dir_key;
  logic [TIME_BITS-1:0]   off_sel;
  logic                   ds_sel;
  logic [TgtW:0]          wanted;
  logic [TgtW-1:0]        ct_target;
  reason_t                ct_reason;
  logic                   ct_due;
  logic [TIME_BITS-1:0]   elapsed_inc;
  logic                   release_now;

  assign is_dir_key = (item.position == cfg.left_position) ||
                      (item.position == cfg.right_position);

  // direction key uses its own press time; release uses the stored one
  assign off_sel = (item.operation == OP_OTHER) ? elapsed_r : dir_offset_r;
  assign ds_sel  = (item.operation == OP_OTHER) ? 1'b1 : dir_hit_r;
  assign wanted  = (TgtW+1)'(off_sel) + (TgtW+1)'(cfg.tail_ms);

  always_comb begin
    if (!ds_sel) begin
      ct_target = TgtW'(cfg.max_hold_ms);
      ct_reason = RS_MAX;
    end else if (wanted < (TgtW+1)'(cfg.min_hold_ms)) begin
      ct_target = TgtW'(cfg.min_hold_ms);
      ct_reason = RS_MIN;
    end else if (wanted > (TgtW+1)'(cfg.max_hold_ms)) begin
      ct_target = TgtW'(cfg.max_hold_ms);
      ct_reason = RS_MAX;
    end else begin
      ct_target = wanted[TgtW-1:0];
      ct_reason = RS_TAIL;
    end
  end

  assign ct_due = (TgtW'(elapsed_r) >= ct_target);

  assign elapsed_inc = ((phase_r != PH_IDLE) && (elapsed_r != {TIME_BITS{1'b1}})) ?
                       elapsed_r + TIME_BITS'(1) : elapsed_r;

  always_comb begin
    phase_nxt      = phase_r;
    held_code_nxt  = held_code_r;
    elapsed_nxt    = elapsed_r;
    dir_hit_nxt    = dir_hit_r;
    dir_offset_nxt = dir_offset_r;
    target_nxt     = target_r;
    reason_nxt     = reason_r;
    release_now    = 1'b0;
    result         = '{hid_action: ACT_NONE, reported_code: 32'd0,
                       up_reason: RS_NONE, phase: PH_IDLE};

    case (item.operation)
      OP_TICK: begin
        elapsed_nxt = elapsed_inc;
        release_now = (phase_r == PH_PENDING) && (TgtW'(elapsed_inc) >= target_r);
      end
      OP_PRESS: begin
        if (phase_r == PH_IDLE) begin
          held_code_nxt        = item.key_code;
          elapsed_nxt          = '0;
          dir_hit_nxt          = 1'b0;
          phase_nxt            = PH_HELD;
          result.hid_action    = ACT_DOWN;
          result.reported_code = item.key_code;
        end else if (phase_r == PH_PENDING) begin
          phase_nxt   = PH_HELD;
          elapsed_nxt = '0;
          dir_hit_nxt = 1'b0;
        end
      end
      OP_RELEASE: begin
        if (phase_r == PH_HELD) begin
          if (TgtW'(elapsed_r) >= TgtW'(cfg.max_hold_ms)) begin
            reason_nxt  = RS_LONG;
            release_now = 1'b1;
          end else begin
            phase_nxt   = PH_PENDING;
            target_nxt  = ct_target;
            reason_nxt  = ct_reason;
            release_now = ct_due;
          end
        end
      end
      OP_OTHER: begin
        if (is_dir_key && (phase_r != PH_IDLE) && !dir_hit_r) begin
          dir_hit_nxt    = 1'b1;
          dir_offset_nxt = elapsed_r;
          if (phase_r == PH_PENDING) begin
            target_nxt  = ct_target;
            reason_nxt  = ct_reason;
            release_now = ct_due;
          end
        end
      end
      default: ;
    endcase

    if (release_now) begin
      result.hid_action    = ACT_UP;
      result.reported_code = held_code_r;
      result.up_reason     = reason_nxt;
      phase_nxt            = PH_IDLE;
    end
    result.phase = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      held_code_r  <= '0;
      elapsed_r    <= '0;
      dir_hit_r    <= 1'b0;
      dir_offset_r <= '0;
      target_r     <= '0;
      reason_r     <= RS_NONE;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      held_code_r  <= held_code_nxt;
      elapsed_r    <= elapsed_nxt;
      dir_hit_r    <= dir_hit_nxt;
      dir_offset_r <= dir_offset_nxt;
      target_r     <= target_nxt;
      reason_r     <= reason_nxt;
    end
  end

endmodule

>>> rtl/direction_anchored_key_hold.sv
// Stretched hold of one trigger key, driven by an event stream.
// Input channel (in_valid / in_stall / in_item): one item per event, either a
// one millisecond tick, a trigger press, a trigger release or another key's
// press with its position. Every accepted item yields exactly one result.
// Result channel (out_valid / out_stall / out_item): the HID edge to report
// (none, down, up), the held key code, the release reason and the phase left
// behind by the item.
// The result of an accepted item is registered and shown in the cycle after
// it is taken. Throughput is one item per cycle while the receiver does not
// stall; the session state update and the target clamp form a single
// add-and-compare step between the state registers and the result register.
// When the receiver stalls, the result register holds its item and in_stall
// rises in the same cycle, so no item is lost; as soon as the result is taken
// a new item is accepted in that very cycle.
// Reset (rst_n low, synchronous) returns the session to idle, clears the
// timers and the result valid flag, loads the register defaults (tail 100,
// min 50, max 400, direction positions 16 and 18) and stalls the input.
// Configuration: cfg_we with cfg_index and cfg_wdata writes one register per
// edge; write only while no item is in flight.
module direction_anchored_key_hold import dakh_pkg::*; #(
  parameter int TIME_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t      cfg_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t step_result;
  logic      accept;

  // Hold the input in reset and while the result register is full and not taken.
  assign in_stall = !rst_n || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // Register bank: take one write per edge, drop unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{tail_ms: TAIL_RST, min_hold_ms: MIN_RST, max_hold_ms: MAX_RST,
                 left_position: LEFT_RST, right_position: RIGHT_RST};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAIL:  cfg_r.tail_ms        <= cfg_wdata;
        CFG_MIN:   cfg_r.min_hold_ms    <= cfg_wdata;
        CFG_MAX:   cfg_r.max_hold_ms    <= cfg_wdata;
        CFG_LEFT:  cfg_r.left_position  <= cfg_wdata[7:0];
        CFG_RIGHT: cfg_r.right_position <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Session state and the per-item step.
  dakh_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .item    (in_item),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  // Result register: load on accept, drop valid once taken, hold under stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> rtl/dakh_checker.sv
module dakh_checker import dakh_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or vanished");

  // every accepted item shows a result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.hid_action == ACT_NONE) |->
      (out_item.up_reason == RS_NONE) && (out_item.reported_code == 32'd0))
    else $error("no-edge result carries code or reason");

  a_up_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.hid_action == ACT_UP) |->
      (out_item.phase == PH_IDLE) && (out_item.up_reason != RS_NONE))
    else $error("key up without idle phase or reason");

  a_down_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.hid_action == ACT_DOWN) |->
      (out_item.phase == PH_HELD) && (out_item.up_reason == RS_NONE))
    else $error("key down without held phase");

endmodule

bind direction_anchored_key_hold dakh_checker u_dakh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

>>> sim/key_hold_checker.sv
`timescale 1ns / 100ps

module key_hold_checker import dakh_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_item_t            in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_item_t           out_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int                  fail_count,
  output int                  outstanding,
  output int                  checked_count,
  output int                  release_count
);

  localparam logic [15:0] TimeMax = 16'hFFFF;

  // Own copy of the registers and the session
  cfg_t        regs;
  phase_t      phase_q;
  logic [31:0] held_code;
  logic [15:0] elapsed;
  logic        dir_hit;
  logic [15:0] dir_offset;
  logic [15:0] release_at;
  reason_t     reason_q;

  out_item_t   hid_reports[$];

  // Aim the release: direction time plus tail, minimum tested first; with no
  // direction seen, the maximum. Return true when the release is already due.
  function automatic logic aim_release();
    logic [16:0] wanted;
    wanted = {1'b0, dir_offset} + {1'b0, regs.tail_ms};
    if (!dir_hit) begin
      release_at = regs.max_hold_ms;
      reason_q   = RS_MAX;
    end else if (wanted < {1'b0, regs.min_hold_ms}) begin
      release_at = regs.min_hold_ms;
      reason_q   = RS_MIN;
    end else if (wanted > {1'b0, regs.max_hold_ms}) begin
      release_at = regs.max_hold_ms;
      reason_q   = RS_MAX;
    end else begin
      release_at = wanted[15:0];
      reason_q   = RS_TAIL;
    end
    return elapsed >= release_at;
  endfunction

  function automatic out_item_t hold_step(in_item_t it);
    out_item_t r;
    logic      fire;
    r    = '0;
    fire = 1'b0;
    case (it.operation)
      OP_TICK: begin
        if (phase_q != PH_IDLE && elapsed != TimeMax) elapsed = elapsed + 16'd1;
        if (phase_q == PH_PENDING && elapsed >= release_at) fire = 1'b1;
      end
      OP_PRESS: begin
        if (phase_q == PH_IDLE) begin
          held_code       = it.key_code;
          elapsed         = '0;
          dir_hit         = 1'b0;
          phase_q         = PH_HELD;
          r.hid_action    = ACT_DOWN;
          r.reported_code = held_code;
        end else if (phase_q == PH_PENDING) begin
          // re-press: cancel the release, keep the code
          phase_q = PH_HELD;
          elapsed = '0;
          dir_hit = 1'b0;
        end
      end
      OP_RELEASE: begin
        if (phase_q == PH_HELD) begin
          if (elapsed >= regs.max_hold_ms) begin
            reason_q = RS_LONG;
            fire     = 1'b1;
          end else begin
            phase_q = PH_PENDING;
            fire    = aim_release();
          end
        end
      end
      default: begin
        if ((it.position == regs.left_position || it.position == regs.right_position) &&
            phase_q != PH_IDLE && !dir_hit) begin
          dir_hit    = 1'b1;
          dir_offset = elapsed;
          if (phase_q == PH_PENDING) fire = aim_release();
        end
      end
    endcase
    if (fire) begin
      r.hid_action    = ACT_UP;
      r.reported_code = held_code;
      r.up_reason     = reason_q;
      phase_q         = PH_IDLE;
    end
    r.phase = phase_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      regs.tail_ms        = TAIL_RST;
      regs.min_hold_ms    = MIN_RST;
      regs.max_hold_ms    = MAX_RST;
      regs.left_position  = LEFT_RST;
      regs.right_position = RIGHT_RST;
      phase_q    = PH_IDLE;
      held_code  = '0;
      elapsed    = '0;
      dir_hit    = 1'b0;
      dir_offset = '0;
      release_at = '0;
      reason_q   = RS_NONE;
      hid_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        checked_count++;
        if (out_item.hid_action == ACT_UP) release_count++;
        if (hid_reports.size() == 0) begin
          $error("result with no item waiting for it: %h", out_item);
          fail_count++;
        end else begin
          want = hid_reports.pop_front();
          if (out_item.hid_action !== want.hid_action) begin
            $error("hid_action: expected %0d, actual %0d", want.hid_action,
                   out_item.hid_action);
            fail_count++;
          end
          if (out_item.reported_code !== want.reported_code) begin
            $error("reported_code: expected %h, actual %h", want.reported_code,
                   out_item.reported_code);
            fail_count++;
          end
          if (out_item.up_reason !== want.up_reason) begin
            $error("up_reason: expected %0d, actual %0d", want.up_reason,
                   out_item.up_reason);
            fail_count++;
          end
          if (out_item.phase !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, out_item.phase);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TAIL:  regs.tail_ms        = cfg_wdata;
          CFG_MIN:   regs.min_hold_ms    = cfg_wdata;
          CFG_MAX:   regs.max_hold_ms    = cfg_wdata;
          CFG_LEFT:  regs.left_position  = cfg_wdata[7:0];
          CFG_RIGHT: regs.right_position = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) hid_reports.push_back(hold_step(in_item));
    end
    outstanding <= hid_reports.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dakh_pkg::*;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_we    = 1'b0;
  logic [2:0]          cfg_index = CFG_TAIL;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int fail_count;
  int outstanding;
  int checked_count;
  int release_count;

  // Idle chances in percent for the sender and the receiver
  int send_gap_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent    = 0;
  int settings_used = 0;
  cfg_t cur_cfg;

  direction_anchored_key_hold u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  key_hold_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count),
    .release_count (release_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: stall at random, one decision per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Present one item and hold it until the block takes it; insert random
  // gaps before it so idle cycles land on every phase of the session.
  task automatic send_item(op_t op, logic [31:0] code, logic [7:0] pos);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{operation: op, key_code: code, position: pos};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop sending and wait until every expected result has come back, then
  // let the result register settle before going on.
  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all five registers on consecutive edges. Position writes carry
  // junk in the upper byte, which the block must drop.
  task automatic write_config(cfg_t c);
    logic [7:0] junk;
    junk      = 8'($urandom);
    cur_cfg   = c;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TAIL;
    cfg_wdata <= c.tail_ms;
    @(posedge clk);
    cfg_index <= CFG_MIN;
    cfg_wdata <= c.min_hold_ms;
    @(posedge clk);
    cfg_index <= CFG_MAX;
    cfg_wdata <= c.max_hold_ms;
    @(posedge clk);
    cfg_index <= CFG_LEFT;
    cfg_wdata <= {junk, c.left_position};
    @(posedge clk);
    cfg_index <= CFG_RIGHT;
    cfg_wdata <= {~junk, c.right_position};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic cfg_t make_setting(logic [15:0] tail, logic [15:0] lo,
                                        logic [15:0] hi, logic [7:0] left,
                                        logic [7:0] right);
    cfg_t c;
    c.tail_ms        = tail;
    c.min_hold_ms    = lo;
    c.max_hold_ms    = hi;
    c.left_position  = left;
    c.right_position = right;
    return c;
  endfunction

  // Short hold windows so that sessions actually reach their release; flavors 1
  // to 4 push one register to an edge, flavor 5 both positions.
  function automatic cfg_t pick_setting(int flavor);
    cfg_t c;
    c = make_setting(16'($urandom_range(0, 20)), 16'($urandom_range(0, 25)),
                     16'($urandom_range(0, 40)), 8'($urandom), 8'($urandom));
    case (flavor)
      1: c.tail_ms = 16'hFFFF;                  // tail overflows 16 bits
      2: c.min_hold_ms = 16'hFFFF;              // minimum above maximum
      3: c.max_hold_ms = 16'h0000;              // every release is a long hold
      4: c.right_position = c.left_position;    // both direction keys alike
      5: begin
        c.left_position  = 8'h00;
        c.right_position = 8'hFF;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] any_code();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One event inside a session: mostly ticks, some direction keys, stray
  // keys, and now and then a press or a release out of turn.
  task automatic session_event(bit released);
    int  pick;
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      send_item(OP_TICK, $urandom, 8'($urandom));
    end else if (pick < 87) begin
      send_item(OP_OTHER, $urandom,
                $urandom_range(0, 1) ? cur_cfg.left_position : cur_cfg.right_position);
    end else if (pick < 93) begin
      send_item(OP_OTHER, $urandom, 8'($urandom));
    end else if (pick < (released ? 97 : 95)) begin
      send_item(OP_PRESS, any_code(), 8'($urandom));
    end else begin
      send_item(OP_RELEASE, $urandom, 8'($urandom));
    end
  endtask

  // Well-formed session: press, hold a while, release, then run out the
  // pending window (which may re-press or end early).
  task automatic run_session();
    int held_len;
    int tail_len;
    held_len = $urandom_range(0, 20);
    tail_len = $urandom_range(0, 45);
    send_item(OP_PRESS, any_code(), 8'($urandom));
    repeat (held_len) session_event(1'b0);
    send_item(OP_RELEASE, $urandom, 8'($urandom));
    repeat (tail_len) session_event(1'b1);
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 6)) begin
      send_item(op_t'($urandom_range(0, 3)), $urandom, 8'($urandom));
    end
  endtask

  initial begin : stimulus
    int goal;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct   = 34;
    recv_stall_pct = 46;

    // Directed: tiny windows, direction keys at position extremes
    write_config(make_setting(16'd1, 16'd3, 16'd6, 8'h00, 8'hFF));
    send_item(OP_TICK, 32'h1234_5678, 8'h00);     // idle tick does not count
    send_item(OP_RELEASE, 32'h0, 8'h00);          // release while idle
    send_item(OP_OTHER, 32'h0, 8'h00);            // direction key while idle
    send_item(OP_PRESS, 32'hFFFF_FFFF, 8'hFF);    // key down
    send_item(OP_PRESS, 32'h0000_0000, 8'h00);    // press while held
    send_item(OP_TICK, 32'h0, 8'h00);
    send_item(OP_OTHER, 32'h0, 8'hFF);            // direction seen at 1 ms
    send_item(OP_OTHER, 32'h0, 8'h00);            // second direction ignored
    send_item(OP_OTHER, 32'h0, 8'd77);            // unrelated key
    send_item(OP_RELEASE, 32'h0, 8'h00);          // target clamps up to the minimum
    send_item(OP_TICK, 32'h0, 8'h00);
    send_item(OP_RELEASE, 32'h0, 8'h00);          // release while pending
    send_item(OP_TICK, 32'h0, 8'h00);             // up edge, min clamp
    send_item(OP_PRESS, 32'h0000_0000, 8'h00);
    send_item(OP_RELEASE, 32'h0, 8'h00);          // no direction: wait for max
    send_item(OP_PRESS, 32'hA5A5_5A5A, 8'h00);    // re-press keeps the old code
    send_item(OP_TICK, 32'h0, 8'h00);
    send_item(OP_TICK, 32'h0, 8'h00);
    send_item(OP_RELEASE, 32'h0, 8'h00);
    send_item(OP_OTHER, 32'h0, 8'h00);            // direction while pending moves target
    send_item(OP_TICK, 32'h0, 8'h00);             // up edge, direction tail
    drain_reports();

    // Directed: target already passed, and a long physical hold
    write_config(make_setting(16'd0, 16'd0, 16'd2, 8'd16, 8'd18));
    send_item(OP_PRESS, 32'h5A5A_A5A5, 8'h00);
    send_item(OP_TICK, 32'h0, 8'h00);
    send_item(OP_RELEASE, 32'h0, 8'h00);
    send_item(OP_OTHER, 32'h0, 8'd18);            // target lands at or before now
    send_item(OP_PRESS, 32'h0F0F_F0F0, 8'h00);
    send_item(OP_TICK, 32'h0, 8'h00);
    send_item(OP_TICK, 32'h0, 8'h00);
    send_item(OP_RELEASE, 32'h0, 8'h00);          // up at once, long hold

    // Random sessions: receiver-heavy stalling, then sender-heavy idling, then none
    for (int mode = 0; mode < 3; mode++) begin
      send_gap_pct   = (mode == 0) ? 34 : (mode == 1) ? 46 : 0;
      recv_stall_pct = (mode == 0) ? 46 : (mode == 1) ? 34 : 0;
      for (int k = 0; k < 4; k++) begin
        drain_reports();
        write_config(pick_setting((mode * 4 + k) % 6));
        goal = items_sent + 76;
        while (items_sent < goal) begin
          if ($urandom_range(0, 99) < 15) run_noise();
          else run_session();
        end
      end
    end
    drain_reports();

    $display("covered %0d items under %0d register settings, %0d results checked",
             items_sent, settings_used, checked_count);
    $display("%0d key-up edges across clamped, tail and long-hold releases",
             release_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Bound the run well past the slowest correct one
  initial begin : watchdog
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
rtl/dakh_pkg.sv
rtl/dakh_engine.sv
rtl/direction_anchored_key_hold.sv
rtl/dakh_checker.sv
sim/key_hold_checker.sv
sim/testbench.sv
